@@ hw/rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants for the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int unsigned POOL_BYTES_DEF = 65536;
	localparam int unsigned MIN_BLOCK_DEF  = 128;
	localparam int unsigned ORDER_W        = 4;
	localparam int unsigned HDR_W          = 7;
	localparam logic [HDR_W-1:0] HDR_RESET = 7'd24;

	localparam logic       FUNC_ALLOC = 1'b0;
	localparam logic       FUNC_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic               begins;
		logic               busy;
		logic [ORDER_W-1:0] order;
	} slot_t;

	localparam int unsigned SLOT_BITS = $bits(slot_t);

endpackage

@@ hw/rtl/bba_slot_ram.sv @@
// ----------------------------------------------------------------------------
// bba_slot_ram
// per-slot state memory, one write and one registered read port
// ----------------------------------------------------------------------------
module bba_slot_ram #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  bba_pkg::slot_t            wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output bba_pkg::slot_t            rd_data
);
	import bba_pkg::*;

	slot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/buddy_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// buddy allocator over a fixed pool, slot state held in one memory
// ----------------------------------------------------------------------------
//  channel | signals                                   | moves
//  in      | in_valid/in_ready, func, req_bytes,       | one request word
//          | block_addr                                |
//  out     | out_valid/out_ready, status,              | one result word
//          | granted_addr, granted_bytes               |
//  cfg     | cfg_wr_en, cfg_wr_data                    | header_bytes write
//
// allocate: prepare, walk the pool block by block, split down to the needed order, then result
// free: check the block, then a buddy read and a merge write per merge, then result
// the slot memory port sets the pace
// after reset a clearing pass over all POOL_BYTES/MIN_BLOCK slots holds in_ready low
// one request at a time; a waiting result does not block the next request
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit #(
	parameter int unsigned POOL_BYTES = bba_pkg::POOL_BYTES_DEF,
	parameter int unsigned MIN_BLOCK  = bba_pkg::MIN_BLOCK_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [bba_pkg::HDR_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      func,
	input  logic [15:0]               req_bytes,
	input  logic [15:0]               block_addr,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [15:0]               granted_addr,
	output logic [16:0]               granted_bytes
);
	import bba_pkg::*;

	localparam int unsigned NSLOTS  = POOL_BYTES / MIN_BLOCK;
	localparam int unsigned TOP     = $clog2(NSLOTS);
	localparam int unsigned SW      = (TOP < 1) ? 1 : TOP;
	localparam int unsigned MIN_LOG = $clog2(MIN_BLOCK);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_PREP  = 4'd2;
	localparam logic [3:0] S_SCAN  = 4'd3;
	localparam logic [3:0] S_SPLIT = 4'd4;
	localparam logic [3:0] S_FCHK  = 4'd5;
	localparam logic [3:0] S_FBUD  = 4'd6;
	localparam logic [3:0] S_FWLO  = 4'd7;
	localparam logic [3:0] S_RES   = 4'd8;

	logic [3:0]         state_q;
	logic [HDR_W-1:0]   hdr_q;
	logic               func_q;
	logic [15:0]        req_q;
	logic [15:0]        addr_q;
	logic [SW-1:0]      cur_q;
	logic [SW-1:0]      best_q;
	logic [ORDER_W-1:0] best_ord_q;
	logic [ORDER_W-1:0] need_q;
	logic [ORDER_W-1:0] o_q;
	logic               found_q;
	logic [1:0]         rst_q;
	logic [15:0]        raddr_q;
	logic [16:0]        rbytes_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [15:0]        granted_addr_q;
	logic [16:0]        granted_bytes_q;

	logic               wr_en;
	logic [SW-1:0]      wr_addr;
	slot_t              wr_data;
	logic               rd_en;
	logic [SW-1:0]      rd_addr;
	slot_t              rd_data;

	bba_slot_ram #(.DEPTH(NSLOTS), .AW(SW)) u_ram (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	logic [16:0]        total;
	logic [ORDER_W-1:0] need_ord;
	logic               fits;
	logic               addr_ok;
	logic [31:0]        slot_w;
	logic               cand;
	logic [31:0]        nxt;
	logic [SW-1:0]      bit_o;
	logic [SW-1:0]      bit_d;

	always_comb begin
		total    = 17'(req_q) + 17'(hdr_q);
		fits     = 32'(total) <= 32'(POOL_BYTES);
		need_ord = ORDER_W'(TOP);
		for (int k = TOP; k >= 0; k--) begin
			if ((32'(MIN_BLOCK) << k) >= 32'(total)) begin
				need_ord = ORDER_W'(k);
			end
		end
		addr_ok = ((32'(addr_q) & 32'(MIN_BLOCK - 1)) == 32'd0) &&
			(32'(addr_q) < 32'(POOL_BYTES));
		slot_w  = 32'(addr_q) >> MIN_LOG;
		cand    = rd_data.begins && !rd_data.busy && rd_data.order >= need_q &&
			(!found_q || rd_data.order < best_ord_q);
		nxt     = 32'(cur_q) + (32'd1 << rd_data.order);
		bit_o   = SW'(1) << o_q;
		bit_d   = SW'(1) << rd_data.order;
	end

	logic       res_go;
	logic [1:0] res_st;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = cur_q;
		res_go  = 1'b0;
		res_st  = ST_OK;
		unique case (state_q)
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = cur_q;
				if (cur_q == '0) begin
					wr_data = '{begins: 1'b1, busy: 1'b0, order: ORDER_W'(TOP)};
				end
			end
			S_PREP: begin
				if (func_q == FUNC_ALLOC) begin
					rd_en   = (req_q != '0) && fits;
					rd_addr = '0;
				end else begin
					rd_en   = addr_ok;
					rd_addr = slot_w[SW-1:0];
				end
			end
			S_SCAN: begin
				if (nxt < 32'(NSLOTS)) begin
					rd_en   = 1'b1;
					rd_addr = nxt[SW-1:0];
				end
			end
			S_SPLIT: begin
				wr_en = 1'b1;
				if (best_ord_q > need_q) begin
					wr_addr = best_q + (SW'(1) << (best_ord_q - 1'b1));
					wr_data = '{begins: 1'b1, busy: 1'b0, order: best_ord_q - 1'b1};
				end else begin
					wr_addr = best_q;
					wr_data = '{begins: 1'b1, busy: 1'b1, order: need_q};
				end
			end
			S_FCHK: begin
				if (rd_data.begins && rd_data.busy) begin
					wr_en   = 1'b1;
					wr_data = '{begins: 1'b1, busy: 1'b0, order: rd_data.order};
					rd_en   = 32'(rd_data.order) < 32'(TOP);
					rd_addr = cur_q ^ bit_d;
				end
			end
			S_FBUD: begin
				if (rd_data.begins && !rd_data.busy && rd_data.order == o_q) begin
					wr_en   = 1'b1;
					wr_addr = cur_q | bit_o;
				end
			end
			S_FWLO: begin
				wr_en   = 1'b1;
				wr_data = '{begins: 1'b1, busy: 1'b0, order: o_q};
				rd_en   = 32'(o_q) < 32'(TOP);
				rd_addr = cur_q ^ bit_o;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			hdr_q       <= HDR_RESET;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				hdr_q <= cfg_wr_data;
			end
			if (state_q == S_RES && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					cur_q <= cur_q + 1'b1;
					if (32'(cur_q) == 32'(NSLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						req_q   <= req_bytes;
						addr_q  <= block_addr;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					rbytes_q <= '0;
					raddr_q  <= '0;
					found_q  <= 1'b0;
					need_q   <= need_ord;
					if (func_q == FUNC_ALLOC) begin
						cur_q <= '0;
						if (req_q == '0) begin
							rst_q   <= ST_INVALID;
							state_q <= S_RES;
						end else if (!fits) begin
							rst_q   <= ST_NOFIT;
							state_q <= S_RES;
						end else begin
							state_q <= S_SCAN;
						end
					end else begin
						cur_q <= slot_w[SW-1:0];
						if (addr_ok) begin
							state_q <= S_FCHK;
						end else begin
							rst_q   <= ST_INVALID;
							state_q <= S_RES;
						end
					end
				end
				S_SCAN: begin
					if (cand) begin
						found_q    <= 1'b1;
						best_q     <= cur_q;
						best_ord_q <= rd_data.order;
					end
					if (nxt < 32'(NSLOTS)) begin
						cur_q <= nxt[SW-1:0];
					end else if (found_q || cand) begin
						state_q <= S_SPLIT;
					end else begin
						rst_q   <= ST_NOFIT;
						state_q <= S_RES;
					end
				end
				S_SPLIT: begin
					if (best_ord_q > need_q) begin
						best_ord_q <= best_ord_q - 1'b1;
					end else begin
						rst_q    <= ST_OK;
						raddr_q  <= 16'(32'(best_q) << MIN_LOG);
						rbytes_q <= 17'(32'(MIN_BLOCK) << need_q);
						state_q  <= S_RES;
					end
				end
				S_FCHK: begin
					o_q <= rd_data.order;
					if (!(rd_data.begins && rd_data.busy)) begin
						rst_q   <= ST_INVALID;
						state_q <= S_RES;
					end else if (32'(rd_data.order) < 32'(TOP)) begin
						state_q <= S_FBUD;
					end else begin
						rst_q   <= ST_OK;
						state_q <= S_RES;
					end
				end
				S_FBUD: begin
					if (rd_data.begins && !rd_data.busy && rd_data.order == o_q) begin
						cur_q   <= cur_q & ~bit_o;
						o_q     <= o_q + 1'b1;
						state_q <= S_FWLO;
					end else begin
						rst_q   <= ST_OK;
						state_q <= S_RES;
					end
				end
				S_FWLO: begin
					if (32'(o_q) < 32'(TOP)) begin
						state_q <= S_FBUD;
					end else begin
						rst_q   <= ST_OK;
						state_q <= S_RES;
					end
				end
				S_RES: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RES && (!out_valid_q || out_ready)) begin
			status_q        <= rst_q;
			granted_addr_q  <= raddr_q;
			granted_bytes_q <= rbytes_q;
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_addr  = granted_addr_q;
	assign granted_bytes = granted_bytes_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !in_ready)
		else $error("request taken during clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !wr_en)
		else $error("slot write during pool walk");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (granted_addr == '0 && granted_bytes == '0))
		else $error("grant fields set on failed request");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_PREP))
		else $error("accepted word not processed");

endmodule
